// ===== rtl/wsfd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

    typedef enum logic [5:0] {
        PH_HDR0 = 6'b000001,
        PH_HDR1 = 6'b000010,
        PH_EXT  = 6'b000100,
        PH_KEY  = 6'b001000,
        PH_DATA = 6'b010000,
        PH_ERR  = 6'b100000
    } phase_t;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PAYLOAD = 2'd0;
    localparam kind_t KIND_EMPTY   = 2'd1;
    localparam kind_t KIND_UNMASK  = 2'd2;

    localparam logic [7:0] HDR_TOP_BIT   = 8'h80;
    localparam logic [7:0] HDR_OPC_MASK  = 8'h0F;
    localparam logic [6:0] LEN_CODE_16   = 7'd126;
    localparam logic [6:0] LEN_CODE_64   = 7'd127;
    localparam logic [3:0] EXT_BYTES_16  = 4'd2;
    localparam logic [3:0] EXT_BYTES_64  = 4'd8;
    localparam logic [3:0] KEY_BYTES     = 4'd4;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// WebSocket client-to-server deframer: header decode, length, mask key, unmasking.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------------------
//  in      | sink      | in_valid/in_stall | stream_byte[7:0], restart
//  out     | source    | out_valid/out_stall | kind[1:0], payload_byte[7:0],
//          |           |                   | frame_opcode[3:0], final_fragment, last_of_frame
//
// One beat per clock sustained while the output is not stalled. An accepted beat
// is held in the input register, then the frame state is updated and any result
// lands in the output register. The frame state advances only when the input
// register drains into the output stage, so out_stall holds both stages; in_stall
// rises only when the input register is full and cannot move. rst_n clears phase
// and frame state.
module websocket_frame_deframer
    import wsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] stream_byte,
    input  logic       restart,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] payload_byte,
    output logic [3:0] frame_opcode,
    output logic       final_fragment,
    output logic       last_of_frame
);

    // ---------------- input register ----------------
    logic       iv_reg;
    logic [7:0] ibyte_reg;
    logic       irestart_reg;

    // ---------------- output register ----------------
    logic       ov_reg;
    kind_t      kind_reg;
    logic [7:0] pbyte_reg;
    logic [3:0] opc_out_reg;
    logic       fin_out_reg;
    logic       last_reg;

    // ---------------- frame state ----------------
    phase_t      phase_reg,    phase_next;
    logic [3:0]  opcode_reg,   opcode_next;
    logic        fin_reg,      fin_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [63:0] rem_len_reg,  rem_len_next;
    logic [31:0] key_reg,      key_next;
    logic [1:0]  key_idx_reg,  key_idx_next;

    // result produced by the beat in the input register
    logic       res_valid;
    kind_t      res_kind;
    logic [7:0] res_byte;
    logic       res_last;

    logic       out_ready;   // output register can take a new result
    logic       advance;     // input register moves on this cycle
    logic [7:0] key_byte;
    logic [3:0] ext_dec;
    logic [6:0] len_code;

    assign out_ready = !ov_reg || !out_stall;
    assign advance   = iv_reg && out_ready;
    assign in_stall  = iv_reg && !out_ready;

    assign ext_dec  = ext_left_reg - 4'd1;
    assign len_code = ibyte_reg[6:0];

    // key byte for this payload position; first key byte is the top byte
    always_comb
    begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        fin_next      = fin_reg;
        ext_left_next = ext_left_reg;
        rem_len_next  = rem_len_reg;
        key_next      = key_reg;
        key_idx_next  = key_idx_reg;
        res_valid     = 1'b0;
        res_kind      = KIND_PAYLOAD;
        res_byte      = 8'd0;
        res_last      = 1'b0;

        if (irestart_reg)
        begin
            // abandon the frame and drop any error
            phase_next    = PH_HDR0;
            opcode_next   = 4'd0;
            fin_next      = 1'b0;
            ext_left_next = 4'd0;
            rem_len_next  = 64'd0;
            key_next      = 32'd0;
            key_idx_next  = 2'd0;
        end
        else
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    fin_next    = |(ibyte_reg & HDR_TOP_BIT);
                    opcode_next = ibyte_reg[3:0] & HDR_OPC_MASK[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (!(|(ibyte_reg & HDR_TOP_BIT)))
                    begin
                        // client frames must be masked
                        phase_next = PH_ERR;
                        res_valid  = 1'b1;
                        res_kind   = KIND_UNMASK;
                    end
                    else if (len_code == LEN_CODE_16)
                    begin
                        rem_len_next  = 64'd0;
                        ext_left_next = EXT_BYTES_16;
                        phase_next    = PH_EXT;
                    end
                    else if (len_code == LEN_CODE_64)
                    begin
                        rem_len_next  = 64'd0;
                        ext_left_next = EXT_BYTES_64;
                        phase_next    = PH_EXT;
                    end
                    else
                    begin
                        rem_len_next  = {57'd0, len_code};
                        ext_left_next = KEY_BYTES;
                        phase_next    = PH_KEY;
                    end
                end
                PH_EXT:
                begin
                    // big-endian extended length
                    rem_len_next = {rem_len_reg[55:0], ibyte_reg};
                    if (ext_dec == 4'd0)
                    begin
                        ext_left_next = KEY_BYTES;
                        phase_next    = PH_KEY;
                    end
                    else
                    begin
                        ext_left_next = ext_dec;
                    end
                end
                PH_KEY:
                begin
                    key_next      = {key_reg[23:0], ibyte_reg};
                    ext_left_next = ext_dec;
                    if (ext_dec == 4'd0)
                    begin
                        key_idx_next = 2'd0;
                        if (rem_len_reg == 64'd0)
                        begin
                            phase_next = PH_HDR0;
                            res_valid  = 1'b1;
                            res_kind   = KIND_EMPTY;
                            res_last   = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    key_idx_next = key_idx_reg + 2'd1;
                    rem_len_next = rem_len_reg - 64'd1;
                    res_valid    = 1'b1;
                    res_kind     = KIND_PAYLOAD;
                    res_byte     = ibyte_reg ^ key_byte;
                    res_last     = (rem_len_reg == 64'd1);
                    if (rem_len_reg == 64'd1)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                PH_ERR:
                begin
                    // hold until restart
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg       <= 1'b0;
            ov_reg       <= 1'b0;
            phase_reg    <= PH_HDR0;
            opcode_reg   <= 4'd0;
            fin_reg      <= 1'b0;
            ext_left_reg <= 4'd0;
            rem_len_reg  <= 64'd0;
            key_reg      <= 32'd0;
            key_idx_reg  <= 2'd0;
        end
        else
        begin
            if (!in_stall)
            begin
                iv_reg <= in_valid;
            end
            if (out_ready)
            begin
                ov_reg <= advance && res_valid;
            end
            if (advance)
            begin
                phase_reg    <= phase_next;
                opcode_reg   <= opcode_next;
                fin_reg      <= fin_next;
                ext_left_reg <= ext_left_next;
                rem_len_reg  <= rem_len_next;
                key_reg      <= key_next;
                key_idx_reg  <= key_idx_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            ibyte_reg    <= stream_byte;
            irestart_reg <= restart;
        end
        if (advance && res_valid)
        begin
            kind_reg    <= res_kind;
            pbyte_reg   <= res_byte;
            opc_out_reg <= opcode_reg;
            fin_out_reg <= fin_reg;
            last_reg    <= res_last;
        end
    end

    assign out_valid      = ov_reg;
    assign kind           = kind_reg;
    assign payload_byte   = pbyte_reg;
    assign frame_opcode   = opc_out_reg;
    assign final_fragment = fin_out_reg;
    assign last_of_frame  = last_reg;

endmodule
